// File: hw/rtl/rv32sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc_pkg
// Shared types, opcodes and function codes for the RV32I subset core.
// ----------------------------------------------------------------------------
package rv32sc_pkg;

   localparam int XLEN             = 32;
   localparam int REG_COUNT        = 32;
   localparam int REG_ADDR_W       = 5;
   localparam int DATA_WORDS       = 32;
   localparam int DADDR_W          = $clog2(DATA_WORDS);
   localparam int NEXT_PC_W        = 10;
   localparam int PC_WIDTH_DEFAULT = 10;
   localparam int SHAMT_W          = 5;

   typedef enum logic [1:0] {
      REQ_EXEC     = 2'd0,
      REQ_PRELOAD  = 2'd1,
      REQ_READ_REG = 2'd2,
      REQ_READ_MEM = 2'd3
   } req_kind_type;

   localparam logic [6:0] OP_R      = 7'b0110011;
   localparam logic [6:0] OP_I      = 7'b0010011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;

   localparam logic [2:0] F3_ADD = 3'b000;
   localparam logic [2:0] F3_SLL = 3'b001;
   localparam logic [2:0] F3_SLT = 3'b010;
   localparam logic [2:0] F3_SUB = 3'b011;
   localparam logic [2:0] F3_XOR = 3'b100;
   localparam logic [2:0] F3_SRL = 3'b101;
   localparam logic [2:0] F3_OR  = 3'b110;
   localparam logic [2:0] F3_AND = 3'b111;

   localparam logic [2:0] F3_BEQ  = 3'b000;
   localparam logic [2:0] F3_BNE  = 3'b001;
   localparam logic [2:0] F3_BLT  = 3'b100;
   localparam logic [2:0] F3_BGE  = 3'b101;
   localparam logic [2:0] F3_BLTU = 3'b110;
   localparam logic [2:0] F3_BGEU = 3'b111;

   typedef struct packed {
      logic wr_req;
      logic is_link;
      logic is_load;
      logic is_store;
      logic redirect;
   } exec_ctrl_type;

endpackage

// File: hw/rtl/rv32sc_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32sc_exec
// Instruction decode, ALU, branch compare and address generation.
// ----------------------------------------------------------------------------
module rv32sc_exec (
   input  logic [rv32sc_pkg::XLEN-1:0] instr,
   input  logic [rv32sc_pkg::XLEN-1:0] src_a,
   input  logic [rv32sc_pkg::XLEN-1:0] src_b,
   output rv32sc_pkg::exec_ctrl_type   ctrl,
   output logic [rv32sc_pkg::XLEN-1:0] result,
   output logic [rv32sc_pkg::XLEN-1:0] mem_addr,
   output logic [rv32sc_pkg::XLEN-1:0] pc_offset
);
   import rv32sc_pkg::*;

   logic [6:0]      opcode;
   logic [2:0]      funct3;
   logic [XLEN-1:0] imm_i;
   logic [XLEN-1:0] imm_s;
   logic [XLEN-1:0] imm_j;
   logic            lt_s;
   logic            lt_u;

   assign opcode = instr[6:0];
   assign funct3 = instr[14:12];
   assign imm_i  = {{20{instr[31]}}, instr[31:20]};
   assign imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_j  = {{12{instr[31]}}, instr[31:12]};
   assign lt_s   = $signed(src_a) < $signed(src_b);
   assign lt_u   = src_a < src_b;

   always_comb begin
      ctrl      = '0;
      result    = '0;
      mem_addr  = '0;
      pc_offset = '0;
      unique case (opcode)
         OP_R: begin
            ctrl.wr_req = 1'b1;
            case (funct3)
               F3_ADD:  result = src_a + src_b;
               F3_SLL:  result = src_a << src_b[SHAMT_W-1:0];
               F3_SLT:  result = {{(XLEN-1){1'b0}}, lt_s};
               F3_SUB:  result = src_a - src_b;
               F3_XOR:  result = src_a ^ src_b;
               F3_SRL:  result = src_a >> src_b[SHAMT_W-1:0];
               F3_OR:   result = src_a | src_b;
               default: result = src_a & src_b;
            endcase
         end
         OP_I: begin
            ctrl.wr_req = 1'b1;
            case (funct3)
               F3_ADD:  result = src_a + imm_i;
               F3_SLL:  result = src_a << imm_i[SHAMT_W-1:0];
               F3_XOR:  result = src_a ^ imm_i;
               F3_SRL:  result = src_a >> imm_i[SHAMT_W-1:0];
               F3_OR:   result = src_a | imm_i;
               F3_AND:  result = src_a & imm_i;
               default: ctrl.wr_req = 1'b0;
            endcase
         end
         OP_LOAD: begin
            ctrl.is_load = 1'b1;
            mem_addr     = src_a + imm_i;
         end
         OP_STORE: begin
            ctrl.is_store = 1'b1;
            mem_addr      = src_a + imm_s;
         end
         OP_JAL: begin
            ctrl.wr_req   = 1'b1;
            ctrl.is_link  = 1'b1;
            ctrl.redirect = 1'b1;
            pc_offset     = imm_j;
         end
         OP_BRANCH: begin
            pc_offset = imm_s;
            case (funct3)
               F3_BEQ:  ctrl.redirect = (src_a == src_b);
               F3_BNE:  ctrl.redirect = (src_a != src_b);
               F3_BLT:  ctrl.redirect = lt_s;
               F3_BGE:  ctrl.redirect = !lt_s;
               F3_BLTU: ctrl.redirect = lt_u;
               F3_BGEU: ctrl.redirect = !lt_u;
               default: ctrl.redirect = 1'b0;
            endcase
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/rv32_subset_single_cycle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core
// Core for a subset of RV32I with flop register file and data memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* (valid/ready). req_type selects execute,
//   data preload, register read or data word read. Every request yields
//   exactly one response on rsp_* (valid/ready), in order.
//   A request passes the input register, then the response register.
//   Throughput: one request per cycle while rsp_ready stays high.
//   Register file reads are captured at acceptance; a write retiring
//   on that same edge is bypassed from a one-entry hold register, so
//   dependent instructions run back to back.
//   State (register file, data memory, pc) updates when a request moves
//   from the input register to the response register.
//   Reset: pc is zero; register file and data memory read as zero through
//   per-entry valid bits cleared by reset. No clearing pass is needed.
//   Stall: when rsp_ready is low with a response held, one more request
//   can wait in the input register, then req_ready drops.
// ----------------------------------------------------------------------------
module rv32_subset_single_cycle_core #(
   parameter int PC_WIDTH = rv32sc_pkg::PC_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_type,
   input  logic [rv32sc_pkg::XLEN-1:0]             req_instr_word,
   input  logic [rv32sc_pkg::REG_ADDR_W-1:0]       req_access_index,
   input  logic signed [rv32sc_pkg::XLEN-1:0]      req_preload_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [rv32sc_pkg::NEXT_PC_W-1:0]        rsp_next_pc,
   output logic signed [rv32sc_pkg::XLEN-1:0]      rsp_read_value,
   output logic                                    rsp_reg_written,
   output logic [rv32sc_pkg::REG_ADDR_W-1:0]       rsp_dest_index,
   output logic signed [rv32sc_pkg::XLEN-1:0]      rsp_dest_value,
   output logic                                    rsp_mem_fault
);
   import rv32sc_pkg::*;

   // storage
   logic [XLEN-1:0]       reg_mem [REG_COUNT];
   logic [REG_COUNT-1:0]  reg_valid_ff;
   logic [XLEN-1:0]       dmem_ff [DATA_WORDS];
   logic [DATA_WORDS-1:0] dmem_valid_ff;
   logic [PC_WIDTH-1:0]   pc_ff;
   logic [PC_WIDTH-1:0]   pc_in;

   // input stage
   logic                  s1_valid_ff;
   req_kind_type          s1_kind_ff;
   logic [XLEN-1:0]       s1_instr_ff;
   logic [REG_ADDR_W-1:0] s1_index_ff;
   logic [XLEN-1:0]       s1_pval_ff;
   logic [REG_ADDR_W-1:0] s1_addr_a_ff;
   logic [REG_ADDR_W-1:0] s1_addr_b_ff;
   logic [XLEN-1:0]       rd_a_ff;
   logic [XLEN-1:0]       rd_b_ff;
   logic                  byp_en_ff;
   logic [REG_ADDR_W-1:0] byp_addr_ff;
   logic [XLEN-1:0]       byp_data_ff;

   // response stage
   logic                  rsp_valid_ff;
   logic [NEXT_PC_W-1:0]  rsp_next_pc_ff;
   logic [XLEN-1:0]       rsp_read_value_ff;
   logic                  rsp_reg_written_ff;
   logic [REG_ADDR_W-1:0] rsp_dest_index_ff;
   logic [XLEN-1:0]       rsp_dest_value_ff;
   logic                  rsp_mem_fault_ff;

   logic                  accept;
   logic                  advance;
   req_kind_type          kind_in;
   logic [REG_ADDR_W-1:0] addr_a_in;
   logic [REG_ADDR_W-1:0] addr_b_in;

   logic [XLEN-1:0]       src_a;
   logic [XLEN-1:0]       src_b;
   exec_ctrl_type         ctrl;
   logic [XLEN-1:0]       alu_result;
   logic [XLEN-1:0]       mem_addr;
   logic [XLEN-1:0]       pc_offset;

   logic                  mem_ok;
   logic                  idx_ok;
   logic [DADDR_W-1:0]    dm_raddr;
   logic [XLEN-1:0]       dm_rdata;
   logic [PC_WIDTH-1:0]   pc_plus1;
   logic [PC_WIDTH-1:0]   pc_target;
   logic [PC_WIDTH+XLEN-1:0]      link_wide;
   logic [PC_WIDTH+NEXT_PC_W-1:0] npc_wide;

   logic                  wr_req;
   logic [XLEN-1:0]       wr_val;
   logic                  rf_we;
   logic [REG_ADDR_W-1:0] rf_waddr;
   logic                  dm_we;
   logic [DADDR_W-1:0]    dm_waddr;
   logic [XLEN-1:0]       dm_wdata;
   logic [XLEN-1:0]       read_val;
   logic                  fault;

   // handshake
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign kind_in   = req_kind_type'(req_type);
   assign addr_a_in = (kind_in == REQ_EXEC) ? req_instr_word[19:15] : req_access_index;
   assign addr_b_in = req_instr_word[24:20];

   // operand bypass for the write retiring on the capture edge
   assign src_a = (byp_en_ff && byp_addr_ff == s1_addr_a_ff) ? byp_data_ff : rd_a_ff;
   assign src_b = (byp_en_ff && byp_addr_ff == s1_addr_b_ff) ? byp_data_ff : rd_b_ff;

   rv32sc_exec u_exec (
      .instr     (s1_instr_ff),
      .src_a     (src_a),
      .src_b     (src_b),
      .ctrl      (ctrl),
      .result    (alu_result),
      .mem_addr  (mem_addr),
      .pc_offset (pc_offset)
   );

   assign mem_ok   = mem_addr < XLEN'(DATA_WORDS);
   assign idx_ok   = XLEN'(s1_index_ff) < XLEN'(DATA_WORDS);
   assign dm_raddr = (s1_kind_ff == REQ_READ_MEM) ? s1_index_ff[DADDR_W-1:0]
                                                  : mem_addr[DADDR_W-1:0];
   assign dm_rdata = dmem_valid_ff[dm_raddr] ? dmem_ff[dm_raddr] : '0;

   assign pc_plus1  = pc_ff + 1'b1;
   assign pc_target = pc_ff + pc_offset[PC_WIDTH-1:0];
   assign link_wide = {{XLEN{1'b0}}, pc_plus1};
   assign npc_wide  = {{NEXT_PC_W{1'b0}}, pc_in};

   always_comb begin
      pc_in    = pc_ff;
      wr_req   = 1'b0;
      wr_val   = '0;
      dm_we    = 1'b0;
      dm_waddr = s1_index_ff[DADDR_W-1:0];
      dm_wdata = s1_pval_ff;
      read_val = '0;
      fault    = 1'b0;
      unique case (s1_kind_ff)
         REQ_PRELOAD: begin
            if (idx_ok) begin
               dm_we = 1'b1;
            end else begin
               fault = 1'b1;
            end
         end
         REQ_READ_REG: begin
            read_val = src_a;
         end
         REQ_READ_MEM: begin
            if (idx_ok) begin
               read_val = dm_rdata;
            end else begin
               fault = 1'b1;
            end
         end
         default: begin
            pc_in = ctrl.redirect ? pc_target : pc_plus1;
            if (ctrl.is_load) begin
               if (mem_ok) begin
                  wr_req = 1'b1;
                  wr_val = dm_rdata;
               end else begin
                  fault = 1'b1;
               end
            end else if (ctrl.is_store) begin
               if (mem_ok) begin
                  dm_we    = 1'b1;
                  dm_waddr = mem_addr[DADDR_W-1:0];
                  dm_wdata = src_b;
               end else begin
                  fault = 1'b1;
               end
            end else if (ctrl.wr_req) begin
               wr_req = 1'b1;
               wr_val = ctrl.is_link ? link_wide[XLEN-1:0] : alu_result;
            end
         end
      endcase
   end

   assign rf_waddr = s1_instr_ff[11:7];
   assign rf_we    = wr_req && (rf_waddr != '0);

   // register file: write on retire, registered reads on accept
   always_ff @(posedge clock) begin
      if (advance && rf_we) begin
         reg_mem[rf_waddr] <= wr_val;
      end
      if (accept) begin
         rd_a_ff <= reg_valid_ff[addr_a_in] ? reg_mem[addr_a_in] : '0;
         rd_b_ff <= reg_valid_ff[addr_b_in] ? reg_mem[addr_b_in] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
      end else if (advance && rf_we) begin
         reg_valid_ff[rf_waddr] <= 1'b1;
      end
   end

   // data memory
   always_ff @(posedge clock) begin
      if (advance && dm_we) begin
         dmem_ff[dm_waddr] <= dm_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dmem_valid_ff <= '0;
      end else if (advance && dm_we) begin
         dmem_valid_ff[dm_waddr] <= 1'b1;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_en_ff   <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         byp_en_ff   <= advance && rf_we;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= kind_in;
         s1_instr_ff  <= req_instr_word;
         s1_index_ff  <= req_access_index;
         s1_pval_ff   <= req_preload_value;
         s1_addr_a_ff <= addr_a_in;
         s1_addr_b_ff <= addr_b_in;
         byp_addr_ff  <= rf_waddr;
         byp_data_ff  <= wr_val;
      end
   end

   // pc
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (advance) begin
         pc_ff <= pc_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_next_pc_ff     <= npc_wide[NEXT_PC_W-1:0];
         rsp_read_value_ff  <= read_val;
         rsp_reg_written_ff <= rf_we;
         rsp_dest_index_ff  <= rf_we ? rf_waddr : '0;
         rsp_dest_value_ff  <= rf_we ? wr_val : '0;
         rsp_mem_fault_ff   <= fault;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_reg_written = rsp_reg_written_ff;
   assign rsp_dest_index  = rsp_dest_index_ff;
   assign rsp_dest_value  = rsp_dest_value_ff;
   assign rsp_mem_fault   = rsp_mem_fault_ff;

   // assertions
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_reg_written_ff |-> rsp_dest_index_ff != '0)
      else $error("response reports a write to x0");

   a_x0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !reg_valid_ff[0])
      else $error("x0 marked as written");

   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      advance && s1_kind_ff != REQ_EXEC |=> pc_ff == $past(pc_ff))
      else $error("pc moved on a non-execute request");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mem_fault_ff |-> !rsp_reg_written_ff)
      else $error("faulting request wrote a register");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      advance && rf_we |=> reg_valid_ff[$past(rf_waddr)])
      else $error("retired register write not marked valid");

endmodule
